### rtl/md5bc_pkg.sv
package md5bc_pkg;

  localparam int unsigned WORDS_PER_BLOCK = 16;
  localparam int unsigned ROUNDS          = 64;
  // Two pipeline steps sit in front of the round unit, and a fold step comes after it.
  localparam logic [6:0]  LAST_STEP       = 7'd66;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  typedef enum logic [1:0] {
    FN_F,
    FN_G,
    FN_H,
    FN_I
  } fn_t;

  typedef enum logic {
    OP_RUN,
    OP_FOLD
  } op_t;

  typedef struct packed {
    logic       rd_en;
    logic [3:0] rd_idx;
    logic       km_en;
    logic [5:0] k_idx;
    logic       rnd_en;
    fn_t        fn;
    logic [4:0] shift;
    op_t        op;
  } ucode_t;

  localparam logic [31:0] ROUND_K [ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROUND_SHIFT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [7:0] rw;
    logic [7:0] idx;
    begin
      rw = {2'b00, r};
      case (r[5:4])
        2'd0:    idx = rw;
        2'd1:    idx = 8'(rw * 8'd5 + 8'd1);
        2'd2:    idx = 8'(rw * 8'd3 + 8'd5);
        default: idx = 8'(rw * 8'd7);
      endcase
      msg_index = idx[3:0];
    end
  endfunction

  // Microprogram: step s reads the message word of round s, adds the round
  // constant for round s-1, and runs round s-2. The last step folds the result.
  function automatic ucode_t ucode(input logic [6:0] step);
    ucode_t     u;
    logic [6:0] km_r;
    logic [6:0] rn_r;
    begin
      km_r     = 7'(step - 7'd1);
      rn_r     = 7'(step - 7'd2);
      u.rd_en  = (step < 7'd64);
      u.rd_idx = msg_index(step[5:0]);
      u.km_en  = (step >= 7'd1) && (step <= 7'd64);
      u.k_idx  = km_r[5:0];
      u.rnd_en = (step >= 7'd2) && (step <= 7'd65);
      u.fn     = fn_t'(rn_r[5:4]);
      u.shift  = ROUND_SHIFT[{rn_r[5:4], rn_r[1:0]}];
      u.op     = (step == LAST_STEP) ? OP_FOLD : OP_RUN;
      ucode    = u;
    end
  endfunction

endpackage

### rtl/md5_block_compress.sv
// MD5 block compression over a stream of 32-bit words. Each word is byte
// reversed and stored; the sixteenth word of a block starts a 64-round MD5
// compression against the kept chaining value, and the updated chaining value
// comes out as one digest transaction. A word with restart set reloads the
// standard initial value and becomes word 0 of a new block. While a block is
// filling, one word is taken per cycle. After the sixteenth word, word_stall
// stays high while a small microprogram steps a single round unit through
// the 64 rounds (two pipeline steps to fetch the message word and add the
// round constant, then one fold step); the fold step waits further if the
// previous digest has not yet been taken. No padding is applied: input is
// taken as whole blocks.
module md5_block_compress (
  input  logic        clk,
  input  logic        rst,
  input  logic        word_valid,
  output logic        word_stall,
  input  logic [31:0] word,
  input  logic        restart,
  output logic        digest_valid,
  input  logic        digest_stall,
  output logic [31:0] digest_a,
  output logic [31:0] digest_b,
  output logic [31:0] digest_c,
  output logic [31:0] digest_d
);

  logic [31:0] msg_mem [md5bc_pkg::WORDS_PER_BLOCK];

  logic        running;
  logic [6:0]  step;
  logic [3:0]  word_count;
  logic [31:0] chain_a, chain_b, chain_c, chain_d;
  logic [31:0] a, b, c, d;
  logic [31:0] mdata;
  logic [31:0] km;

  md5bc_pkg::ucode_t uc;

  logic        word_take;
  logic [3:0]  wr_idx;
  logic [31:0] word_swapped;
  logic [31:0] f;
  logic [31:0] t;
  logic [63:0] t_rot;
  logic        fold_hold;
  logic        fold_step;

  assign uc           = md5bc_pkg::ucode(step);
  assign word_stall   = running;
  assign word_take    = word_valid && !running;
  assign wr_idx       = restart ? 4'd0 : word_count;
  assign word_swapped = {word[7:0], word[15:8], word[23:16], word[31:24]};
  assign fold_hold    = digest_valid && digest_stall;
  assign fold_step    = running && (uc.op == md5bc_pkg::OP_FOLD);

  always_comb begin
    case (uc.fn)
      md5bc_pkg::FN_F: f = d ^ (b & (c ^ d));
      md5bc_pkg::FN_G: f = c ^ (d & (b ^ c));
      md5bc_pkg::FN_H: f = b ^ c ^ d;
      md5bc_pkg::FN_I: f = c ^ (b | ~d);
      default:         f = b ^ c ^ d;
    endcase
    t     = a + f + km;
    t_rot = {t, t} << uc.shift;
  end

  always_ff @(posedge clk) begin
    if (word_take) begin
      msg_mem[wr_idx] <= word_swapped;
    end
    if (running && uc.rd_en) begin
      mdata <= msg_mem[uc.rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (running && uc.km_en) begin
      km <= mdata + md5bc_pkg::ROUND_K[uc.k_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running      <= 1'b0;
      step         <= '0;
      word_count   <= '0;
      digest_valid <= 1'b0;
      chain_a      <= md5bc_pkg::IV_A;
      chain_b      <= md5bc_pkg::IV_B;
      chain_c      <= md5bc_pkg::IV_C;
      chain_d      <= md5bc_pkg::IV_D;
    end else begin
      // During the fold step a taken digest is replaced by the new one.
      if (digest_valid && !digest_stall && !fold_step) begin
        digest_valid <= 1'b0;
      end
      if (word_take) begin
        word_count <= 4'(wr_idx + 4'd1);
        if (restart) begin
          chain_a <= md5bc_pkg::IV_A;
          chain_b <= md5bc_pkg::IV_B;
          chain_c <= md5bc_pkg::IV_C;
          chain_d <= md5bc_pkg::IV_D;
        end
        if (wr_idx == 4'd15) begin
          running <= 1'b1;
          step    <= '0;
          a       <= restart ? md5bc_pkg::IV_A : chain_a;
          b       <= restart ? md5bc_pkg::IV_B : chain_b;
          c       <= restart ? md5bc_pkg::IV_C : chain_c;
          d       <= restart ? md5bc_pkg::IV_D : chain_d;
        end
      end
      if (running) begin
        if (uc.rnd_en) begin
          a <= d;
          d <= c;
          c <= b;
          b <= b + t_rot[63:32];
        end
        case (uc.op)
          md5bc_pkg::OP_RUN: begin
            step <= 7'(step + 7'd1);
          end
          md5bc_pkg::OP_FOLD: begin
            // The fold waits here until the output register is free.
            if (!fold_hold) begin
              chain_a      <= chain_a + a;
              chain_b      <= chain_b + b;
              chain_c      <= chain_c + c;
              chain_d      <= chain_d + d;
              digest_a     <= chain_a + a;
              digest_b     <= chain_b + b;
              digest_c     <= chain_c + c;
              digest_d     <= chain_d + d;
              digest_valid <= 1'b1;
              running      <= 1'b0;
              step         <= '0;
            end
          end
          default: begin
            step <= '0;
          end
        endcase
      end
    end
  end

endmodule

### tb/sv/md5_block_compress_tb.sv
module md5_block_compress_tb;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 80;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int unsigned ROT_AMOUNT [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } digest_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        word_valid   = 1'b0;
  logic        word_stall;
  logic [31:0] word         = '0;
  logic        restart      = 1'b0;
  logic        digest_valid;
  logic        digest_stall = 1'b0;
  logic [31:0] digest_a;
  logic [31:0] digest_b;
  logic [31:0] digest_c;
  logic [31:0] digest_d;

  // Predictor state: message words of the block being filled and the chaining value.
  logic [31:0] msg_buf [16];
  logic [31:0] chain [4];
  int unsigned fill_cnt = 0;
  digest_t     digest_q [$];

  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_words     = 0;
  int unsigned n_restarts  = 0;
  int unsigned n_dropped   = 0;
  int unsigned n_digests   = 0;
  int unsigned errors      = 0;
  digest_t     got;
  digest_t     want;

  md5_block_compress i_dut (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word_stall   (word_stall),
    .word         (word),
    .restart      (restart),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .digest_a     (digest_a),
    .digest_b     (digest_b),
    .digest_c     (digest_c),
    .digest_d     (digest_d)
  );

  always #2 clk = ~clk;

  // Mostly short gaps, some medium, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 120);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h1 << $urandom_range(0, 31);
      3: return ~(32'h1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  task automatic compress_chain();
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] f;
    logic [31:0] t;
    int unsigned m;
    int unsigned s;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = d ^ (b & (c ^ d));
          m = r % 16;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          m = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          m = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          m = (7 * r) % 16;
        end
      endcase
      s = ROT_AMOUNT[(r / 16) * 4 + r % 4];
      t = a + f + ROUND_CONST[r] + msg_buf[m];
      a = d;
      d = c;
      c = b;
      b = b + ((t << s) | (t >> (32 - s)));
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endtask

  task automatic absorb_word(input logic [31:0] w, input logic rs);
    if (rs) begin
      if (fill_cnt != 0) n_dropped++;
      for (int i = 0; i < 4; i++) chain[i] = CHAIN_INIT[i];
      fill_cnt = 0;
      n_restarts++;
    end
    msg_buf[fill_cnt] = {w[7:0], w[15:8], w[23:16], w[31:24]};
    fill_cnt = (fill_cnt + 1) % 16;
    if (fill_cnt == 0) begin
      compress_chain();
      digest_q.push_back(digest_t'{chain[0], chain[1], chain[2], chain[3]});
    end
  endtask

  // Called at a rising edge; returns at the edge where the word transaction completes.
  task automatic send_word(input logic [31:0] w, input logic rs);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? pick_gap() : 0;
    if (gap != 0) begin
      word_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_valid <= 1'b1;
    word       <= w;
    restart    <= rs;
    @(posedge clk);
    while (word_stall) @(posedge clk);
    absorb_word(w, rs);
    n_words++;
  endtask

  task automatic send_message(input int unsigned nblocks);
    for (int i = 0; i < nblocks * 16; i++) send_word(pick_word(), i == 0);
  endtask

  // A partial block from reset, then a full block of extreme words opened by a restart.
  task automatic test_restart_after_partial();
    logic [31:0] w;
    gap_pct   = 0;
    stall_pct = 0;
    repeat (5) send_word(pick_word(), 1'b0);
    for (int i = 0; i < 16; i++) begin
      case (i % 4)
        0: w = 32'h0000_0000;
        1: w = 32'hffff_ffff;
        2: w = 32'h8000_0001;
        default: w = 32'h0123_4567;
      endcase
      send_word(w, i == 0);
    end
  endtask

  task automatic test_chained_messages();
    gap_pct   = 25;
    stall_pct = 20;
    repeat (36) send_message($urandom_range(1, 3));
  endtask

  task automatic test_full_rate();
    gap_pct   = 0;
    stall_pct = 0;
    send_message(12);
  endtask

  task automatic test_heavy_idling();
    gap_pct   = 70;
    stall_pct = 70;
    repeat (4) send_message(2);
  endtask

  // Abandoned partial blocks, then words with restart set at random.
  task automatic test_broken_messages();
    gap_pct   = 20;
    stall_pct = 30;
    repeat (12) begin
      send_word(pick_word(), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(0, 14)) send_word(pick_word(), 1'b0);
      send_message(1);
    end
    repeat (96) send_word(pick_word(), $urandom_range(0, 9) == 0);
    send_message(1);
  endtask

  always @(posedge clk) begin
    if (!rst && digest_valid && !digest_stall) begin
      n_digests++;
      got = digest_t'{digest_a, digest_b, digest_c, digest_d};
      if (digest_q.size() == 0) begin
        $display("%0t: digest with none expected: actual %h %h %h %h",
                 $time, got.a, got.b, got.c, got.d);
        errors++;
      end else begin
        want = digest_q.pop_front();
        check_field("digest_a", want.a, got.a);
        check_field("digest_b", want.b, got.b);
        check_field("digest_c", want.c, got.c);
        check_field("digest_d", want.d, got.d);
      end
    end
    if (stall_left != 0) begin
      digest_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      digest_stall <= 1'b1;
      stall_left = pick_gap() - 1;
    end else begin
      digest_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((word_valid && !word_stall) || (digest_valid && !digest_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d digests outstanding",
               $time, idle_cycles, digest_q.size());
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < 4; i++) chain[i] = CHAIN_INIT[i];
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_restart_after_partial();
    test_chained_messages();
    test_full_rate();
    test_heavy_idling();
    test_broken_messages();
    word_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d words (%0d with restart, %0d partial blocks dropped), checked %0d digests.",
             n_words, n_restarts, n_dropped, n_digests);
    $display("Input gaps and output stalls ranged from none to long; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### md5_block_compress.f
rtl/md5bc_pkg.sv
rtl/md5_block_compress.sv
tb/sv/md5_block_compress_tb.sv
